@@ design/psag_pkg.sv @@
// Shared types and constants for the pixel shuffle address generator.
package psag_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port (byte address is four times the index).
   localparam logic [2:0] CSR_CHANNELS    = 3'd0;
   localparam logic [2:0] CSR_BATCH_COUNT = 3'd1;
   localparam logic [2:0] CSR_OUT_ROWS    = 3'd2;
   localparam logic [2:0] CSR_OUT_COLS    = 3'd3;
   localparam logic [2:0] CSR_RATIO       = 3'd4;
   localparam logic [2:0] CSR_IN_ROWS     = 3'd5;
   localparam logic [2:0] CSR_IN_COLS     = 3'd6;
   localparam logic [2:0] CSR_DIRECTION   = 3'd7;

   // Tensor geometry after clamping to the supported ranges.
   typedef struct packed {
      logic [10:0] channels;
      logic [8:0]  batch_count;
      logic [12:0] out_rows;
      logic [12:0] out_cols;
      logic [3:0]  ratio;
      logic [12:0] in_rows;
      logic [12:0] in_cols;
      logic        direction;
   } cfg_type;

endpackage

@@ design/psag_walker.sv @@
// Front part: accepts requests, steps the tensor walk and queues one position per transfer.
module psag_walker #(
   parameter int CH_W    = 10,
   parameter int BA_W    = 8,
   parameter int DIM_W   = 12,
   parameter int PH_W    = 3,
   parameter int SEQ_W   = 32,
   parameter int ENTRY_W = 1 + SEQ_W + 2 * PH_W + 2 * DIM_W + BA_W + CH_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  psag_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_restart,
   output logic                 push_valid,
   input  logic                 push_ready,
   output logic [ENTRY_W-1:0]   push_data
);

   localparam int POS_W = (DIM_W + 5 > 14) ? DIM_W + 5 : 14;

   logic [CH_W-1:0]  chan_ff, chan_in, chan_cur;
   logic [BA_W-1:0]  batch_ff, batch_in, batch_cur;
   logic [DIM_W-1:0] row_ff, row_in, row_cur;
   logic [DIM_W-1:0] col_ff, col_in, col_cur;
   logic [PH_W-1:0]  rph_ff, rph_in, rph_cur;
   logic [PH_W-1:0]  cph_ff, cph_in, cph_cur;
   logic [SEQ_W-1:0] seq_ff, seq_in, seq_cur;
   logic [POS_W-1:0] orow, ocol;
   logic             col_end, row_end, batch_end, chan_end, last;
   logic             accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign push_data  = {last, seq_cur, cph_cur, rph_cur, col_cur, row_cur, batch_cur, chan_cur};

   always_comb begin
      chan_cur  = req_restart ? '0 : chan_ff;
      batch_cur = req_restart ? '0 : batch_ff;
      row_cur   = req_restart ? '0 : row_ff;
      col_cur   = req_restart ? '0 : col_ff;
      rph_cur   = req_restart ? '0 : rph_ff;
      cph_cur   = req_restart ? '0 : cph_ff;
      seq_cur   = req_restart ? '0 : seq_ff;

      orow = POS_W'(row_cur) * POS_W'(cfg.ratio) + POS_W'(rph_cur);
      ocol = POS_W'(col_cur) * POS_W'(cfg.ratio) + POS_W'(cph_cur);
      col_end   = (ocol + POS_W'(1)) >= POS_W'(cfg.out_cols);
      row_end   = (orow + POS_W'(1)) >= POS_W'(cfg.out_rows);
      batch_end = (10'(batch_cur) + 10'd1) >= 10'(cfg.batch_count);
      chan_end  = (12'(chan_cur) + 12'd1) >= 12'(cfg.channels);
      last      = col_end && row_end && batch_end && chan_end;
   end

   always_comb begin
      chan_in  = chan_ff;
      batch_in = batch_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      rph_in   = rph_ff;
      cph_in   = cph_ff;
      seq_in   = seq_ff;
      if (accept) begin
         if (last) begin
            // The walk wraps to position zero after its final position.
            chan_in  = '0;
            batch_in = '0;
            row_in   = '0;
            col_in   = '0;
            rph_in   = '0;
            cph_in   = '0;
            seq_in   = '0;
         end else begin
            seq_in   = seq_cur + 1'b1;
            chan_in  = chan_cur;
            batch_in = batch_cur;
            row_in   = row_cur;
            col_in   = col_cur;
            rph_in   = rph_cur;
            cph_in   = cph_cur;
            if (!col_end) begin
               if ((5'(cph_cur) + 5'd1) >= 5'(cfg.ratio)) begin
                  cph_in = '0;
                  col_in = col_cur + 1'b1;
               end else begin
                  cph_in = cph_cur + 1'b1;
               end
            end else begin
               cph_in = '0;
               col_in = '0;
               if (!row_end) begin
                  if ((5'(rph_cur) + 5'd1) >= 5'(cfg.ratio)) begin
                     rph_in = '0;
                     row_in = row_cur + 1'b1;
                  end else begin
                     rph_in = rph_cur + 1'b1;
                  end
               end else begin
                  rph_in = '0;
                  row_in = '0;
                  if (!batch_end) begin
                     batch_in = batch_cur + 1'b1;
                  end else begin
                     batch_in = '0;
                     chan_in  = chan_cur + 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= '0;
         batch_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         rph_ff   <= '0;
         cph_ff   <= '0;
         seq_ff   <= '0;
      end else begin
         chan_ff  <= chan_in;
         batch_ff <= batch_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         rph_ff   <= rph_in;
         cph_ff   <= cph_in;
         seq_ff   <= seq_in;
      end
   end

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (seq_ff == '0 && chan_ff == '0 && col_ff == '0))
      else $error("walk did not return to position zero after the last position");

   a_seq_steps: assert property (@(posedge clock) disable iff (reset)
      (accept && !last) |=> (seq_ff == $past(seq_cur) + 1'b1))
      else $error("sequential offset did not advance by one");

endmodule

@@ design/psag_queue.sv @@
// Small register queue that decouples the walker from the address unit.
module psag_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue holds more entries than its depth");

endmodule

@@ design/psag_address_unit.sv @@
// Back part: computes the mapped offset with one shared multiplier and drives the result port.
module psag_address_unit #(
   parameter int CH_W    = 10,
   parameter int BA_W    = 8,
   parameter int DIM_W   = 12,
   parameter int PH_W    = 3,
   parameter int SEQ_W   = 32,
   parameter int ENTRY_W = 1 + SEQ_W + 2 * PH_W + 2 * DIM_W + BA_W + CH_W
) (
   input  logic               clock,
   input  logic               reset,
   input  psag_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  logic [ENTRY_W-1:0] pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_read_address,
   output logic [31:0]        rsp_write_address,
   output logic               rsp_last
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PHASE = 3'd1;
   localparam logic [2:0] ST_DEPTH = 3'd2;
   localparam logic [2:0] ST_BATCH = 3'd3;
   localparam logic [2:0] ST_ROW   = 3'd4;
   localparam logic [2:0] ST_AREA  = 3'd5;
   localparam logic [2:0] ST_MAP   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   localparam logic [31:0] ADDR_MASK = {32{1'b1}} >> (32 - SEQ_W);

   logic [2:0]         state_ff, state_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [31:0]        acc_ff, acc_in, area_ff, area_in, rowoff_ff, rowoff_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_read_ff, rsp_read_in, rsp_write_ff, rsp_write_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               e_last;
   logic [SEQ_W-1:0]   e_seq;
   logic [PH_W-1:0]    e_cph, e_rph;
   logic [DIM_W-1:0]   e_col, e_row;
   logic [BA_W-1:0]    e_batch;
   logic [CH_W-1:0]    e_chan;

   logic [31:0]        mul_a, mul_b, mul_c, mul_out;
   logic [31:0]        mapped, seq;
   logic               pop, load;

   assign {e_last, e_seq, e_cph, e_rph, e_col, e_row, e_batch, e_chan} = entry_ff;

   assign pop_ready         = (state_ff == ST_IDLE);
   assign pop               = pop_valid && pop_ready;
   assign load              = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_address  = rsp_read_ff;
   assign rsp_write_address = rsp_write_ff;
   assign rsp_last          = rsp_last_ff;

   // mapped = ((D*(r*col_phase + row_phase) + c)*B + b)*H*W + row*W + col, built by Horner steps.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_c = '0;
      case (state_ff)
         ST_PHASE: begin
            mul_a = 32'(cfg.ratio);
            mul_b = 32'(e_cph);
            mul_c = 32'(e_rph);
         end
         ST_DEPTH: begin
            mul_a = 32'(cfg.channels);
            mul_b = acc_ff;
            mul_c = 32'(e_chan);
         end
         ST_BATCH: begin
            mul_a = acc_ff;
            mul_b = 32'(cfg.batch_count);
            mul_c = 32'(e_batch);
         end
         ST_ROW: begin
            mul_a = 32'(e_row);
            mul_b = 32'(cfg.in_cols);
            mul_c = 32'(e_col);
         end
         ST_AREA: begin
            mul_a = 32'(cfg.in_rows);
            mul_b = 32'(cfg.in_cols);
         end
         ST_MAP: begin
            mul_a = acc_ff;
            mul_b = area_ff;
            mul_c = rowoff_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
      mul_out = 32'(mul_a * mul_b) + mul_c;
   end

   always_comb begin
      state_in  = state_ff;
      entry_in  = entry_ff;
      acc_in    = acc_ff;
      area_in   = area_ff;
      rowoff_in = rowoff_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               entry_in = pop_data;
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            acc_in   = mul_out;
            state_in = ST_DEPTH;
         end
         ST_DEPTH: begin
            acc_in   = mul_out;
            state_in = ST_BATCH;
         end
         ST_BATCH: begin
            acc_in   = mul_out;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            rowoff_in = mul_out;
            state_in  = ST_AREA;
         end
         ST_AREA: begin
            area_in  = mul_out;
            state_in = ST_MAP;
         end
         ST_MAP: begin
            acc_in   = mul_out;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mapped       = acc_ff & ADDR_MASK;
      seq          = 32'(e_seq);
      rsp_read_in  = rsp_read_ff;
      rsp_write_in = rsp_write_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_read_in  = cfg.direction ? seq : mapped;
         rsp_write_in = cfg.direction ? mapped : seq;
         rsp_last_in  = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      acc_ff       <= acc_in;
      area_ff      <= area_in;
      rowoff_ff    <= rowoff_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_write_ff <= rsp_write_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before its transfer");

   a_pop_idle_only: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_PHASE))
      else $error("queue entry taken outside the idle state");

   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("finished position did not reach the result port");

endmodule

@@ design/pixel_shuffle_address_generator.sv @@
// Top level of the pixel shuffle address generator: register file, walker, queue, address unit.
//
// Each request transfer produces one response transfer carrying the read and write element
// offsets of one position of the channel, batch, row, column walk, plus a flag on the final
// position. The walker takes a request whenever its two-entry queue has room, so up to two
// requests are taken ahead of the arithmetic. The address unit works on each position in turn:
// it takes it from the queue, runs six steps on a single shared 32 by 32 multiplier that builds
// the mapped offset step by step, and loads the response register once that register is free;
// it takes no new position from the queue until it has loaded the result of the last one.
// Registers may be written only while no request is in flight.
module pixel_shuffle_address_generator #(
   parameter int ADDR_BITS    = 32,
   parameter int MAX_CHANNELS = 1024,
   parameter int MAX_BATCH    = 256,
   parameter int MAX_DIM      = 4096,
   parameter int MAX_RATIO    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_read_address,
   output logic [31:0]                     rsp_write_address,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [psag_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [psag_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [psag_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int CH_LIM  = (MAX_CHANNELS < 2047) ? MAX_CHANNELS : 2047;
   localparam int BA_LIM  = (MAX_BATCH < 511) ? MAX_BATCH : 511;
   localparam int DIM_LIM = (MAX_DIM < 8191) ? MAX_DIM : 8191;
   localparam int PH_LIM  = (MAX_RATIO < 15) ? MAX_RATIO : 15;
   localparam int CH_W    = (CH_LIM > 1) ? $clog2(CH_LIM) : 1;
   localparam int BA_W    = (BA_LIM > 1) ? $clog2(BA_LIM) : 1;
   localparam int DIM_W   = (DIM_LIM > 1) ? $clog2(DIM_LIM) : 1;
   localparam int PH_W    = (PH_LIM > 1) ? $clog2(PH_LIM) : 1;
   localparam int SEQ_W   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam int ENTRY_W = 1 + SEQ_W + 2 * PH_W + 2 * DIM_W + BA_W + CH_W;

   logic [10:0] channels_ff, channels_in;
   logic [8:0]  batch_count_ff, batch_count_in;
   logic [12:0] out_rows_ff, out_rows_in;
   logic [12:0] out_cols_ff, out_cols_in;
   logic [3:0]  ratio_ff, ratio_in;
   logic [12:0] in_rows_ff, in_rows_in;
   logic [12:0] in_cols_ff, in_cols_in;
   logic        direction_ff, direction_in;

   logic [2:0]          csr_index;
   logic                csr_write;
   psag_pkg::cfg_type   cfg;

   logic                push_valid, push_ready, pop_valid, pop_ready;
   logic [ENTRY_W-1:0]  push_data, pop_data;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      channels_in    = channels_ff;
      batch_count_in = batch_count_ff;
      out_rows_in    = out_rows_ff;
      out_cols_in    = out_cols_ff;
      ratio_in       = ratio_ff;
      in_rows_in     = in_rows_ff;
      in_cols_in     = in_cols_ff;
      direction_in   = direction_ff;
      if (csr_write) begin
         case (csr_index)
            psag_pkg::CSR_CHANNELS:    channels_in    = csr_pwdata[10:0];
            psag_pkg::CSR_BATCH_COUNT: batch_count_in = csr_pwdata[8:0];
            psag_pkg::CSR_OUT_ROWS:    out_rows_in    = csr_pwdata[12:0];
            psag_pkg::CSR_OUT_COLS:    out_cols_in    = csr_pwdata[12:0];
            psag_pkg::CSR_RATIO:       ratio_in       = csr_pwdata[3:0];
            psag_pkg::CSR_IN_ROWS:     in_rows_in     = csr_pwdata[12:0];
            psag_pkg::CSR_IN_COLS:     in_cols_in     = csr_pwdata[12:0];
            psag_pkg::CSR_DIRECTION:   direction_in   = csr_pwdata[0];
            default: begin
               direction_in = direction_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         psag_pkg::CSR_CHANNELS:    csr_prdata = 32'(channels_ff);
         psag_pkg::CSR_BATCH_COUNT: csr_prdata = 32'(batch_count_ff);
         psag_pkg::CSR_OUT_ROWS:    csr_prdata = 32'(out_rows_ff);
         psag_pkg::CSR_OUT_COLS:    csr_prdata = 32'(out_cols_ff);
         psag_pkg::CSR_RATIO:       csr_prdata = 32'(ratio_ff);
         psag_pkg::CSR_IN_ROWS:     csr_prdata = 32'(in_rows_ff);
         psag_pkg::CSR_IN_COLS:     csr_prdata = 32'(in_cols_ff);
         psag_pkg::CSR_DIRECTION:   csr_prdata = 32'(direction_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_ff    <= 11'd1;
         batch_count_ff <= 9'd1;
         out_rows_ff    <= 13'd1;
         out_cols_ff    <= 13'd1;
         ratio_ff       <= 4'd2;
         in_rows_ff     <= 13'd1;
         in_cols_ff     <= 13'd1;
         direction_ff   <= 1'b0;
      end else begin
         channels_ff    <= channels_in;
         batch_count_ff <= batch_count_in;
         out_rows_ff    <= out_rows_in;
         out_cols_ff    <= out_cols_in;
         ratio_ff       <= ratio_in;
         in_rows_ff     <= in_rows_in;
         in_cols_ff     <= in_cols_in;
         direction_ff   <= direction_in;
      end
   end

   // A zero size is used as one, and a size above its maximum is used as the maximum.
   always_comb begin
      cfg.channels = (channels_ff == '0) ? 11'd1 :
                     (32'(channels_ff) > 32'(MAX_CHANNELS)) ? 11'(MAX_CHANNELS) : channels_ff;
      cfg.batch_count = (batch_count_ff == '0) ? 9'd1 :
                     (32'(batch_count_ff) > 32'(MAX_BATCH)) ? 9'(MAX_BATCH) : batch_count_ff;
      cfg.out_rows = (out_rows_ff == '0) ? 13'd1 :
                     (32'(out_rows_ff) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : out_rows_ff;
      cfg.out_cols = (out_cols_ff == '0) ? 13'd1 :
                     (32'(out_cols_ff) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : out_cols_ff;
      cfg.ratio = (ratio_ff == '0) ? 4'd1 :
                  (32'(ratio_ff) > 32'(MAX_RATIO)) ? 4'(MAX_RATIO) : ratio_ff;
      cfg.in_rows = (in_rows_ff == '0) ? 13'd1 :
                    (32'(in_rows_ff) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : in_rows_ff;
      cfg.in_cols = (in_cols_ff == '0) ? 13'd1 :
                    (32'(in_cols_ff) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : in_cols_ff;
      cfg.direction = direction_ff;
   end

   psag_walker #(
      .CH_W    (CH_W),
      .BA_W    (BA_W),
      .DIM_W   (DIM_W),
      .PH_W    (PH_W),
      .SEQ_W   (SEQ_W),
      .ENTRY_W (ENTRY_W)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   psag_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   psag_address_unit #(
      .CH_W    (CH_W),
      .BA_W    (BA_W),
      .DIM_W   (DIM_W),
      .PH_W    (PH_W),
      .SEQ_W   (SEQ_W),
      .ENTRY_W (ENTRY_W)
   ) u_address_unit (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_address  (rsp_read_address),
      .rsp_write_address (rsp_write_address),
      .rsp_last          (rsp_last)
   );

endmodule

@@ bench/tb_pixel_shuffle_address_generator.sv @@
// Testbench for the pixel shuffle address generator: random request and response pacing with a scoreboard.
module tb_pixel_shuffle_address_generator;

   localparam int MAX_CHANNELS = 1024;
   localparam int MAX_BATCH    = 256;
   localparam int MAX_DIM      = 4096;
   localparam int MAX_RATIO    = 8;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_STALL   = 80;
   localparam int SETTINGS_PER_MIX = 6;
   localparam int ITEMS_PER_SETTING = 45;

   typedef struct {
      logic [31:0] read_addr;
      logic [31:0] write_addr;
      logic        walk_end;
   } addr_pair_type;

   class shuffle_scoreboard;
      psag_pkg::cfg_type regs;
      bit [9:0]      chan_idx;
      bit [7:0]      batch_idx;
      bit [11:0]     row_idx;
      bit [11:0]     col_idx;
      bit [2:0]      row_ph;
      bit [2:0]      col_ph;
      bit [31:0]     seq_off;
      addr_pair_type expected_pairs[$];
      int            errors;
      int            responses;
      int            walk_ends;

      function new();
         regs.channels    = 11'd1;
         regs.batch_count = 9'd1;
         regs.out_rows    = 13'd1;
         regs.out_cols    = 13'd1;
         regs.ratio       = 4'd2;
         regs.in_rows     = 13'd1;
         regs.in_cols     = 13'd1;
         regs.direction   = 1'b0;
         restart_walk();
      endfunction

      function void restart_walk();
         chan_idx  = '0;
         batch_idx = '0;
         row_idx   = '0;
         col_idx   = '0;
         row_ph    = '0;
         col_ph    = '0;
         seq_off   = '0;
      endfunction

      function void write_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            psag_pkg::CSR_CHANNELS:    regs.channels    = value[10:0];
            psag_pkg::CSR_BATCH_COUNT: regs.batch_count = value[8:0];
            psag_pkg::CSR_OUT_ROWS:    regs.out_rows    = value[12:0];
            psag_pkg::CSR_OUT_COLS:    regs.out_cols    = value[12:0];
            psag_pkg::CSR_RATIO:       regs.ratio       = value[3:0];
            psag_pkg::CSR_IN_ROWS:     regs.in_rows     = value[12:0];
            psag_pkg::CSR_IN_COLS:     regs.in_cols     = value[12:0];
            psag_pkg::CSR_DIRECTION:   regs.direction   = value[0];
            default: ;
         endcase
      endfunction

      function longint unsigned clamp(longint unsigned v, longint unsigned hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      // Works out the address pair of the current position, then advances the walk.
      function void note_request(bit restart);
         longint unsigned d, b, orows, ocols, r, h, w;
         longint unsigned depth, mapped, orow, ocol;
         bit col_end, row_end, batch_end, chan_end;
         addr_pair_type pair;
         d     = clamp(regs.channels, MAX_CHANNELS);
         b     = clamp(regs.batch_count, MAX_BATCH);
         orows = clamp(regs.out_rows, MAX_DIM);
         ocols = clamp(regs.out_cols, MAX_DIM);
         r     = clamp(regs.ratio, MAX_RATIO);
         h     = clamp(regs.in_rows, MAX_DIM);
         w     = clamp(regs.in_cols, MAX_DIM);
         if (restart) restart_walk();
         depth  = d * r * col_ph + d * row_ph + chan_idx;
         mapped = depth * b * h * w + batch_idx * h * w + row_idx * w + col_idx;
         orow = row_idx * r + row_ph;
         ocol = col_idx * r + col_ph;
         col_end   = ocol + 1 >= ocols;
         row_end   = orow + 1 >= orows;
         batch_end = batch_idx + 1 >= b;
         chan_end  = chan_idx + 1 >= d;
         pair.walk_end = col_end && row_end && batch_end && chan_end;
         if (regs.direction) begin
            pair.read_addr  = seq_off;
            pair.write_addr = mapped[31:0];
         end else begin
            pair.read_addr  = mapped[31:0];
            pair.write_addr = seq_off;
         end
         expected_pairs.push_back(pair);
         if (pair.walk_end) begin
            restart_walk();
         end else begin
            seq_off = seq_off + 1;
            if (!col_end) begin
               if (col_ph + 1 >= r) begin
                  col_ph = 0;
                  col_idx++;
               end else begin
                  col_ph++;
               end
            end else begin
               col_ph  = 0;
               col_idx = 0;
               if (!row_end) begin
                  if (row_ph + 1 >= r) begin
                     row_ph = 0;
                     row_idx++;
                  end else begin
                     row_ph++;
                  end
               end else begin
                  row_ph  = 0;
                  row_idx = 0;
                  if (!batch_end) begin
                     batch_idx++;
                  end else begin
                     batch_idx = 0;
                     chan_idx++;
                  end
               end
            end
         end
      endfunction

      function void report_error(string what, logic [31:0] exp_v, logic [31:0] act_v);
         errors++;
         $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, what, exp_v, act_v);
      endfunction

      function void check_response(logic [31:0] read_addr, logic [31:0] write_addr,
                                   logic walk_end);
         addr_pair_type pair;
         responses++;
         if (expected_pairs.size() == 0) begin
            errors++;
            $display("%0t: response mismatch, expected none, got read 0x%08h write 0x%08h",
                     $time, read_addr, write_addr);
            return;
         end
         pair = expected_pairs.pop_front();
         if (walk_end === 1'b1) walk_ends++;
         if (read_addr !== pair.read_addr) report_error("read address", pair.read_addr, read_addr);
         if (write_addr !== pair.write_addr)
            report_error("write address", pair.write_addr, write_addr);
         if (walk_end !== pair.walk_end)
            report_error("last flag", {31'd0, pair.walk_end}, {31'd0, walk_end});
      endfunction

      function int pending();
         return expected_pairs.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_restart;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_address;
   logic [31:0] rsp_write_address;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [psag_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [psag_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [psag_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   shuffle_scoreboard sb;
   int sender_idle_pct;
   int receiver_idle_pct;
   int stall_request;
   int hold_left;
   int cycle_count;
   int requests_sent;
   int settings_applied;

   pixel_shuffle_address_generator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_address  (rsp_read_address),
      .rsp_write_address (rsp_write_address),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, sb.pending());
         $display("Verification failed");
         $finish;
      end
   end

   // Response side: check every transfer, then pick the next ready value.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_ready)
         sb.check_response(rsp_read_address, rsp_write_address, rsp_last);
      if (stall_request != 0) begin
         hold_left = LONG_STALL;
         stall_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.write_register(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Places the register value in its low bits and random junk above them.
   function automatic logic [31:0] with_junk(int value, int width);
      logic [31:0] field_mask;
      field_mask = (32'd1 << width) - 1;
      return (value & field_mask) | ($urandom() << width);
   endfunction

   task automatic apply_geometry(input int ch, input int bc, input int orows, input int ocols,
                                 input int r, input int irows, input int icols, input int dir);
      csr_write(psag_pkg::CSR_CHANNELS,    with_junk(ch, 11));
      csr_write(psag_pkg::CSR_BATCH_COUNT, with_junk(bc, 9));
      csr_write(psag_pkg::CSR_OUT_ROWS,    with_junk(orows, 13));
      csr_write(psag_pkg::CSR_OUT_COLS,    with_junk(ocols, 13));
      csr_write(psag_pkg::CSR_RATIO,       with_junk(r, 4));
      csr_write(psag_pkg::CSR_IN_ROWS,     with_junk(irows, 13));
      csr_write(psag_pkg::CSR_IN_COLS,     with_junk(icols, 13));
      csr_write(psag_pkg::CSR_DIRECTION,   with_junk(dir, 1));
      settings_applied++;
   endtask

   task automatic send_request(input bit restart);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(restart);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_random_geometry();
      if ($urandom_range(5) == 0) begin
         apply_geometry($urandom_range(2047), $urandom_range(511), $urandom_range(8191),
                        $urandom_range(8191), $urandom_range(15), $urandom_range(8191),
                        $urandom_range(8191), $urandom_range(1));
      end else begin
         apply_geometry($urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(1, 5),
                        $urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 4),
                        $urandom_range(1, 4), $urandom_range(1));
      end
   endtask

   initial begin
      int sender_pct[3];
      int receiver_pct[3];
      sender_pct   = '{17, 50, 0};
      receiver_pct = '{50, 17, 0};
      sb = new();
      clock = 1'b0;
      cycle_count = 0;
      requests_sent = 0;
      settings_applied = 0;
      stall_request = 0;
      hold_left = 0;
      sender_idle_pct = sender_pct[0];
      receiver_idle_pct = receiver_pct[0];
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_restart <= 1'b0;
      rsp_ready   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry is a one-position walk, so every transfer ends the walk.
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      wait_drained();

      // Output sizes that are not a multiple of the ratio, then the wrap back to zero.
      apply_geometry(1, 1, 3, 3, 2, 2, 2, 0);
      repeat (10) send_request(1'b0);
      wait_drained();

      // All size registers zero clamp to one; backward direction.
      apply_geometry(0, 0, 0, 0, 0, 0, 0, 1);
      repeat (2) send_request(1'b0);
      wait_drained();

      // All-ones registers clamp to the maxima; the mapped offset wraps past 32 bits.
      apply_geometry(2047, 511, 8191, 8191, 15, 8191, 8191, 1);
      send_request(1'b1);
      repeat (7) send_request(1'b0);

      for (int mix = 0; mix < 3; mix++) begin
         for (int s = 0; s < SETTINGS_PER_MIX; s++) begin
            wait_drained();
            sender_idle_pct = sender_pct[mix];
            receiver_idle_pct = receiver_pct[mix];
            apply_random_geometry();
            for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
               if (mix == 0 && s == 1 && i == 10) stall_request = 1;
               send_request($urandom_range(32) == 0);
            end
         end
      end

      wait_drained();
      $display("Run covered %0d requests and %0d responses, %0d of them walk ends, over %0d settings.",
               requests_sent, sb.responses, sb.walk_ends, settings_applied);
      $display("Idle mixes 17/50, 50/17 and none, with one %0d-cycle response stall.", LONG_STALL);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
